@@ hw/rtl/mcc_pkg.sv @@
// Shared types and constants for the methylation context counter.
package mcc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 40;
  localparam int unsigned READ_WIDTH_DEF  = 16;
  localparam int unsigned OUT_W           = 40;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned BASE_W          = 8;
  localparam int unsigned NUM_TOTALS      = 10;
  localparam int unsigned TOT_IDX_W       = $clog2(NUM_TOTALS);
  localparam int unsigned POS_W           = 3;

  localparam logic [POS_W-1:0]  POS_FULL = 3'd4;
  localparam logic [BASE_W-1:0] BASE_C   = 8'h43;
  localparam logic [BASE_W-1:0] BASE_G   = 8'h47;

  // Total indexes, in output order. Each context group is total, meth, unmeth.
  localparam logic [TOT_IDX_W-1:0] IDX_C          = 4'd0;
  localparam logic [TOT_IDX_W-1:0] IDX_CPG        = 4'd1;
  localparam logic [TOT_IDX_W-1:0] IDX_CPG_METH   = 4'd2;
  localparam logic [TOT_IDX_W-1:0] IDX_CPG_UNMETH = 4'd3;
  localparam logic [TOT_IDX_W-1:0] IDX_CHG        = 4'd4;
  localparam logic [TOT_IDX_W-1:0] IDX_CHG_METH   = 4'd5;
  localparam logic [TOT_IDX_W-1:0] IDX_CHG_UNMETH = 4'd6;
  localparam logic [TOT_IDX_W-1:0] IDX_CHH        = 4'd7;
  localparam logic [TOT_IDX_W-1:0] IDX_CHH_METH   = 4'd8;
  localparam logic [TOT_IDX_W-1:0] IDX_CHH_UNMETH = 4'd9;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONT   = 2'd0,
    CMD_START  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CTX_CPG = 2'd0,
    CTX_CHG = 2'd1,
    CTX_CHH = 2'd2
  } ctx_e;

  typedef struct packed {
    logic hit;
    ctx_e ctx;
    logic meth;
    logic unmeth;
  } tally_t;

endpackage

@@ hw/rtl/mcc_classify.sv @@
// Base window, read delay line and context classification of the centre base.
module mcc_classify #(
  parameter int unsigned READ_WIDTH = mcc_pkg::READ_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          start_i,
  input  logic [mcc_pkg::BASE_W-1:0]    base_i,
  input  logic [READ_WIDTH-1:0]         meth_i,
  input  logic [READ_WIDTH-1:0]         unmeth_i,
  input  logic [mcc_pkg::CFG_W-1:0]     min_reads_i,
  output mcc_pkg::tally_t               tally_o
);

  localparam int unsigned CmpW =
      (READ_WIDTH > mcc_pkg::CFG_W) ? READ_WIDTH : mcc_pkg::CFG_W;

  logic [mcc_pkg::BASE_W-1:0] win_q [4];
  logic [READ_WIDTH-1:0]      meth_q [2];
  logic [READ_WIDTH-1:0]      unmeth_q [2];
  logic [mcc_pkg::POS_W-1:0]  pos_q, pos_d, pos_eff;
  logic                       is_c, is_g;
  logic [CmpW-1:0]            min_ext;

  assign pos_eff = start_i ? '0 : pos_q;
  assign is_c    = (win_q[1] == mcc_pkg::BASE_C);
  assign is_g    = (win_q[1] == mcc_pkg::BASE_G);
  assign min_ext = CmpW'(min_reads_i);

  always_comb begin
    tally_o        = '0;
    tally_o.ctx    = mcc_pkg::CTX_CHH;
    tally_o.hit    = step_i && (pos_eff >= mcc_pkg::POS_FULL) && (is_c || is_g);
    if (is_c) begin
      if (win_q[0] == mcc_pkg::BASE_G) begin
        tally_o.ctx = mcc_pkg::CTX_CPG;
      end else if (base_i == mcc_pkg::BASE_G) begin
        tally_o.ctx = mcc_pkg::CTX_CHG;
      end
    end else begin
      if (win_q[2] == mcc_pkg::BASE_C) begin
        tally_o.ctx = mcc_pkg::CTX_CPG;
      end else if (win_q[3] == mcc_pkg::BASE_C) begin
        tally_o.ctx = mcc_pkg::CTX_CHG;
      end
    end
    tally_o.meth   = (CmpW'(meth_q[1]) >= min_ext);
    tally_o.unmeth = !tally_o.meth && (CmpW'(unmeth_q[1]) >= min_ext);
  end

  assign pos_d = (pos_eff < mcc_pkg::POS_FULL) ? pos_eff + 1'b1 : pos_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int k = 0; k < 4; k++) begin
        win_q[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        meth_q[k]   <= '0;
        unmeth_q[k] <= '0;
      end
    end else if (step_i) begin
      pos_q       <= pos_d;
      win_q[3]    <= win_q[2];
      win_q[2]    <= win_q[1];
      win_q[1]    <= win_q[0];
      win_q[0]    <= base_i;
      meth_q[1]   <= meth_q[0];
      meth_q[0]   <= meth_i;
      unmeth_q[1] <= unmeth_q[0];
      unmeth_q[0] <= unmeth_i;
    end
  end

endmodule

@@ hw/rtl/mcc_totals.sv @@
// Ten saturating context counters.
module mcc_totals #(
  parameter int unsigned COUNT_WIDTH = mcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mcc_pkg::tally_t        tally_i,
  output logic [COUNT_WIDTH-1:0] totals_o [mcc_pkg::NUM_TOTALS]
);

  logic [mcc_pkg::NUM_TOTALS-1:0] inc;
  logic [COUNT_WIDTH-1:0]         cnt_q [mcc_pkg::NUM_TOTALS];

  always_comb begin
    inc = '0;
    if (tally_i.hit) begin
      inc[mcc_pkg::IDX_C] = 1'b1;
      case (tally_i.ctx)
        mcc_pkg::CTX_CPG: begin
          inc[mcc_pkg::IDX_CPG]        = 1'b1;
          inc[mcc_pkg::IDX_CPG_METH]   = tally_i.meth;
          inc[mcc_pkg::IDX_CPG_UNMETH] = tally_i.unmeth;
        end
        mcc_pkg::CTX_CHG: begin
          inc[mcc_pkg::IDX_CHG]        = 1'b1;
          inc[mcc_pkg::IDX_CHG_METH]   = tally_i.meth;
          inc[mcc_pkg::IDX_CHG_UNMETH] = tally_i.unmeth;
        end
        mcc_pkg::CTX_CHH: begin
          inc[mcc_pkg::IDX_CHH]        = 1'b1;
          inc[mcc_pkg::IDX_CHH_METH]   = tally_i.meth;
          inc[mcc_pkg::IDX_CHH_UNMETH] = tally_i.unmeth;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < mcc_pkg::NUM_TOTALS; g++) begin : g_cnt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[g] <= '0;
      end else if (inc[g] && (cnt_q[g] != '1)) begin
        cnt_q[g] <= cnt_q[g] + 1'b1;
      end
    end
    assign totals_o[g] = cnt_q[g];
  end

endmodule

@@ hw/rtl/methylation_context_counter.sv @@
// Top level of the methylation context counter.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per
// reference base: command_i, base_i, meth_reads_i, unmeth_reads_i. A base with
// command start opens a new sequence; command report asks for the ten totals.
// The output channel (out_valid_o / out_ready_i) carries one transaction per
// report with the ten saturating totals.
// The user must write min_reads through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce it. Timing: a transaction
// goes to the input register at acceptance; a report passes on to the output
// register. One transaction per cycle is sustained but for the stall below.
// When the receiver stalls, the report waits in the output register; bases
// keep flowing, and only a second report holds the input register (and
// in_ready_o) until the output register frees.
// Reset clears the window, the sequence position, all totals and min_reads
// (zero); bases before any start command belong to a sequence opened at reset.
module methylation_context_counter #(
  parameter int unsigned COUNT_WIDTH = mcc_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned READ_WIDTH  = mcc_pkg::READ_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mcc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mcc_pkg::CMD_W-1:0]    command_i,
  input  logic [mcc_pkg::BASE_W-1:0]   base_i,
  input  logic [READ_WIDTH-1:0]        meth_reads_i,
  input  logic [READ_WIDTH-1:0]        unmeth_reads_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mcc_pkg::OUT_W-1:0]    c_total_o,
  output logic [mcc_pkg::OUT_W-1:0]    cpg_total_o,
  output logic [mcc_pkg::OUT_W-1:0]    cpg_methylated_o,
  output logic [mcc_pkg::OUT_W-1:0]    cpg_unmethylated_o,
  output logic [mcc_pkg::OUT_W-1:0]    chg_total_o,
  output logic [mcc_pkg::OUT_W-1:0]    chg_methylated_o,
  output logic [mcc_pkg::OUT_W-1:0]    chg_unmethylated_o,
  output logic [mcc_pkg::OUT_W-1:0]    chh_total_o,
  output logic [mcc_pkg::OUT_W-1:0]    chh_methylated_o,
  output logic [mcc_pkg::OUT_W-1:0]    chh_unmethylated_o
);

  localparam int unsigned OutW = mcc_pkg::OUT_W;

  logic [mcc_pkg::CFG_W-1:0]  min_reads_q;

  logic                       s1_valid_q, s1_valid_d;
  mcc_pkg::cmd_e              s1_cmd_q;
  logic [mcc_pkg::BASE_W-1:0] s1_base_q;
  logic [READ_WIDTH-1:0]      s1_meth_q, s1_unmeth_q;
  logic                       s1_adv, step, start, report;

  logic                       out_valid_q, out_valid_d;
  logic [OutW-1:0]            out_q [mcc_pkg::NUM_TOTALS];

  mcc_pkg::tally_t            tally;
  logic [COUNT_WIDTH-1:0]     totals [mcc_pkg::NUM_TOTALS];

  always_comb begin
    step   = 1'b0;
    start  = 1'b0;
    report = 1'b0;
    case (s1_cmd_q)
      mcc_pkg::CMD_CONT:   step   = 1'b1;
      mcc_pkg::CMD_START: begin
        step  = 1'b1;
        start = 1'b1;
      end
      mcc_pkg::CMD_REPORT: report = 1'b1;
      default: begin
      end
    endcase
  end

  assign s1_adv      = s1_valid_q && (!report || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !s1_adv);
  assign out_valid_d = (s1_adv && report) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_reads_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_reads_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q    <= mcc_pkg::cmd_e'(command_i);
      s1_base_q   <= base_i;
      s1_meth_q   <= meth_reads_i;
      s1_unmeth_q <= unmeth_reads_i;
    end
    if (s1_adv && report) begin
      for (int k = 0; k < mcc_pkg::NUM_TOTALS; k++) begin
        out_q[k] <= OutW'(totals[k]);
      end
    end
  end

  mcc_classify #(
    .READ_WIDTH (READ_WIDTH)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv && step),
    .start_i     (start),
    .base_i      (s1_base_q),
    .meth_i      (s1_meth_q),
    .unmeth_i    (s1_unmeth_q),
    .min_reads_i (min_reads_q),
    .tally_o     (tally)
  );

  mcc_totals #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_totals (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tally_i  (tally),
    .totals_o (totals)
  );

  assign out_valid_o        = out_valid_q;
  assign c_total_o          = out_q[mcc_pkg::IDX_C];
  assign cpg_total_o        = out_q[mcc_pkg::IDX_CPG];
  assign cpg_methylated_o   = out_q[mcc_pkg::IDX_CPG_METH];
  assign cpg_unmethylated_o = out_q[mcc_pkg::IDX_CPG_UNMETH];
  assign chg_total_o        = out_q[mcc_pkg::IDX_CHG];
  assign chg_methylated_o   = out_q[mcc_pkg::IDX_CHG_METH];
  assign chg_unmethylated_o = out_q[mcc_pkg::IDX_CHG_UNMETH];
  assign chh_total_o        = out_q[mcc_pkg::IDX_CHH];
  assign chh_methylated_o   = out_q[mcc_pkg::IDX_CHH_METH];
  assign chh_unmethylated_o = out_q[mcc_pkg::IDX_CHH_UNMETH];

endmodule

@@ hw/rtl/mcc_checker.sv @@
// Port-level assertions for the methylation context counter, bound to the top.
module mcc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [mcc_pkg::OUT_W-1:0] c_total_o,
  input logic [mcc_pkg::OUT_W-1:0] cpg_total_o,
  input logic [mcc_pkg::OUT_W-1:0] cpg_methylated_o,
  input logic [mcc_pkg::OUT_W-1:0] cpg_unmethylated_o,
  input logic [mcc_pkg::OUT_W-1:0] chg_total_o,
  input logic [mcc_pkg::OUT_W-1:0] chg_methylated_o,
  input logic [mcc_pkg::OUT_W-1:0] chg_unmethylated_o,
  input logic [mcc_pkg::OUT_W-1:0] chh_total_o,
  input logic [mcc_pkg::OUT_W-1:0] chh_methylated_o,
  input logic [mcc_pkg::OUT_W-1:0] chh_unmethylated_o
);

  localparam int unsigned SumW = mcc_pkg::OUT_W + 2;

  logic c_sat;
  assign c_sat = (c_total_o == '1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(c_total_o) && $stable(chh_total_o))
    else $error("output payload changed while stalled");

  a_ctx_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !c_sat |->
      (SumW'(cpg_total_o) + SumW'(chg_total_o) + SumW'(chh_total_o)) == SumW'(c_total_o))
    else $error("context totals do not add up to C total");

  a_call_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !c_sat |->
      ((SumW'(cpg_methylated_o) + SumW'(cpg_unmethylated_o)) <= SumW'(cpg_total_o)) &&
      ((SumW'(chg_methylated_o) + SumW'(chg_unmethylated_o)) <= SumW'(chg_total_o)) &&
      ((SumW'(chh_methylated_o) + SumW'(chh_unmethylated_o)) <= SumW'(chh_total_o)))
    else $error("methylation calls exceed context total");

endmodule

bind methylation_context_counter mcc_checker u_mcc_checker (.*);
